// File: rtl/core/itaf_pkg.sv
// Shared types and constants for the integer to ASCII formatter.
// No dependencies; used by itaf_digits and integer_to_ascii_formatter_top.
package itaf_pkg;

    localparam logic [2:0] FUNC_SDEC = 3'd0;
    localparam logic [2:0] FUNC_UDEC = 3'd1;
    localparam logic [2:0] FUNC_HEXL = 3'd2;
    localparam logic [2:0] FUNC_HEXU = 3'd3;
    localparam logic [2:0] FUNC_OCT  = 3'd4;
    localparam logic [2:0] FUNC_BIN  = 3'd5;
    localparam logic [2:0] FUNC_PTR  = 3'd6;
    localparam logic [2:0] FUNC_RSVD = 3'd7;

    localparam logic [2:0] LEN_CHAR  = 3'd0;
    localparam logic [2:0] LEN_SHORT = 3'd1;
    localparam logic [2:0] LEN_INT   = 3'd2;
    localparam logic [2:0] LEN_LONG  = 3'd3;
    localparam logic [2:0] LEN_LLONG = 3'd4;
    localparam logic [2:0] LEN_SIZE  = 3'd5;

    localparam int unsigned MAX_DIGITS = 64;
    localparam int unsigned BCD_W      = 80;

    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_PLUS  = 8'h2B;
    localparam logic [7:0] CH_MINUS = 8'h2D;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_UA    = 8'h41;
    localparam logic [7:0] CH_LA    = 8'h61;
    localparam logic [7:0] CH_LB    = 8'h62;
    localparam logic [7:0] CH_LX    = 8'h78;
    localparam logic [7:0] CH_UX    = 8'h58;
    localparam logic [39:0] STR_NIL = 40'h29_6C_69_6E_28;

    localparam logic [30:0] COUNT_LIMIT = 31'h7FFF_FFFF;

    typedef logic [9:0] t_cnt;

    typedef struct packed {
        logic       start;
        logic       is_dec;
        logic [2:0] shift;
    } t_dig_req;

    typedef struct packed {
        logic       wr_en;
        logic [5:0] wr_addr;
        logic [3:0] wr_digit;
        logic       done;
        logic [6:0] nd;
    } t_dig_rsp;

endpackage

// File: rtl/core/integer_to_ascii_formatter_top.sv
// Top level of the printf integer formatter: request decode, layout and beat output.
// Depends on itaf_pkg and itaf_digits.
//
// One request is taken at a time. Decimal values pass through the shift and add-three
// converter, then their digits are extracted one at a time; hex, octal and binary digits
// are extracted directly. Layout runs through S_LAY1, S_LAY2 and S_LAY3, then characters
// leave one per cycle into an eight-character beat buffer while it is not full; a full
// buffer waits until the output can take its beat. An overflowing request gives a single
// flagged beat with no characters.
module integer_to_ascii_formatter_top #(
    parameter int unsigned MAX_WIDTH = 255,
    parameter int unsigned LONG_BITS = 64
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // value[63:0], length_code[66:64], left_align[67], zero_fill[68], show_plus[69],
    // space_for_sign[70], alternate_form[71], field_width[79:72], min_digits[88:80],
    // new_call[89], zero[95:90]
    input  logic [95:0] s_axis_tdata,
    // func[2:0]
    input  logic [2:0]  s_axis_tuser,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // char0[7:0] .. char7[63:56], char_count[67:64], zero[71:68]
    output logic [71:0] m_axis_tdata,
    // overflow[0]
    output logic        m_axis_tuser,
    output logic        m_axis_tlast
);

    localparam int unsigned FW_CAP = (MAX_WIDTH < 255) ? MAX_WIDTH : 255;

    typedef enum logic [2:0] {
        S_IDLE, S_PREP, S_DIGITS, S_LAY1, S_LAY2, S_LAY3, S_EMIT, S_OVF
    } t_state;

    t_state              r_state;
    logic [2:0]          r_func;
    logic [63:0]         r_val;
    logic [2:0]          r_lc;
    logic                r_lj, r_zp, r_sp, r_ss, r_alt;
    logic [7:0]          r_fw;
    logic [8:0]          r_md;
    logic [30:0]         r_cw;
    logic [63:0]         r_mag;
    logic                r_neg, r_zero, r_nil;
    logic [6:0]          r_nd;
    logic [2:0]          r_plen;
    logic [39:0]         r_pre;
    logic [8:0]          r_ppad;
    itaf_pkg::t_cnt      r_content, r_fpad;
    itaf_pkg::t_cnt      r_lpad, r_zpad, r_rpad, r_rem;
    logic [6:0]          r_dcnt;
    logic [5:0]          r_dig_idx, n_dig_idx;
    logic [3:0]          r_mem [itaf_pkg::MAX_DIGITS];
    logic [3:0]          r_rd;
    logic [63:0]         r_buf;
    logic [3:0]          r_fill;
    logic                r_out_valid, r_out_last, r_out_ovf;
    logic [63:0]         r_out_chars;
    logic [3:0]          r_out_cnt;

    itaf_pkg::t_dig_req  n_req;
    itaf_pkg::t_dig_rsp  w_rsp;
    logic [6:0]          n_w;
    logic [63:0]         n_mask, n_masked, n_mag;
    logic                n_neg;
    logic                n_has_prec;
    logic [7:0]          n_fw;
    logic [6:0]          n_nd;
    logic [7:0]          n_ch;
    logic                n_gen, n_out_free, n_zfill;
    logic [31:0]         n_sum;

    assign n_has_prec = ~r_md[8];
    assign n_fw = (r_fw > 8'(FW_CAP)) ? 8'(FW_CAP) : r_fw;
    assign n_zfill = r_zp && !r_lj && !n_has_prec && !r_nil;

    always_comb begin
        case (r_lc)
            itaf_pkg::LEN_CHAR:  n_w = (r_func == itaf_pkg::FUNC_BIN) ? 7'd32 : 7'd8;
            itaf_pkg::LEN_SHORT: n_w = (r_func == itaf_pkg::FUNC_BIN) ? 7'd32 : 7'd16;
            itaf_pkg::LEN_LONG:  n_w = 7'(LONG_BITS);
            itaf_pkg::LEN_LLONG: n_w = 7'd64;
            itaf_pkg::LEN_SIZE:  n_w = 7'd64;
            default:             n_w = 7'd32;
        endcase
        if (r_func == itaf_pkg::FUNC_PTR) begin
            n_w = 7'd64;
        end
        n_mask   = (n_w[6]) ? '1 : ((64'd1 << n_w[5:0]) - 64'd1);
        n_masked = r_val & n_mask;
        n_neg    = (r_func == itaf_pkg::FUNC_SDEC) && n_masked[6'(n_w - 7'd1)];
        n_mag    = n_neg ? ((~n_masked + 64'd1) & n_mask) : n_masked;
    end

    always_comb begin
        n_req.start  = (r_state == S_PREP) && !r_nil;
        n_req.is_dec = (r_func == itaf_pkg::FUNC_SDEC) || (r_func == itaf_pkg::FUNC_UDEC);
        case (r_func)
            itaf_pkg::FUNC_OCT: n_req.shift = 3'd3;
            itaf_pkg::FUNC_BIN: n_req.shift = 3'd1;
            default:            n_req.shift = 3'd4;
        endcase
    end

    itaf_digits u_digits (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (n_req),
        .i_mag   (n_mag),
        .o_rsp   (w_rsp)
    );

    assign n_nd = (n_has_prec && r_md[7:0] == 8'd0 && r_zero &&
                   !(r_func == itaf_pkg::FUNC_OCT && r_alt)) ? 7'd0 : r_nd;

    assign n_out_free = !r_out_valid || m_axis_tready;
    assign n_gen = (r_state == S_EMIT) && (r_fill != 4'd8) && (r_rem != '0);
    assign n_sum = {1'b0, r_cw} + {22'b0, r_content + r_fpad};

    always_comb begin
        n_dig_idx = r_dig_idx;
        n_ch = itaf_pkg::CH_SPACE;
        if (r_lpad != '0) begin
            n_ch = itaf_pkg::CH_SPACE;
        end else if (r_plen != 3'd0) begin
            n_ch = r_pre[7:0];
        end else if (r_zpad != '0 || r_ppad != '0) begin
            n_ch = itaf_pkg::CH_ZERO;
        end else if (r_dcnt != 7'd0) begin
            if (r_rd < 4'd10) begin
                n_ch = itaf_pkg::CH_ZERO + {4'b0, r_rd};
            end else begin
                n_ch = ((r_func == itaf_pkg::FUNC_HEXU) ? itaf_pkg::CH_UA : itaf_pkg::CH_LA)
                       + {4'b0, r_rd} - 8'd10;
            end
            if (n_gen) begin
                n_dig_idx = r_dig_idx - 6'd1;
            end
        end
        if (r_state == S_LAY3) begin
            n_dig_idx = 6'(r_nd - 7'd1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_rsp.wr_en) begin
            r_mem[w_rsp.wr_addr] <= w_rsp.wr_digit;
        end
        r_rd <= r_mem[n_dig_idx];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_cw        <= '0;
            r_out_valid <= 1'b0;
            r_fill      <= '0;
            r_rem       <= '0;
        end else begin
            if (r_out_valid && m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
            r_dig_idx <= n_dig_idx;
            case (r_state)
                S_IDLE: begin
                    if (s_axis_tvalid) begin
                        r_func <= (s_axis_tuser == itaf_pkg::FUNC_RSVD) ?
                                  itaf_pkg::FUNC_UDEC : s_axis_tuser;
                        r_val  <= s_axis_tdata[63:0];
                        r_lc   <= s_axis_tdata[66:64];
                        r_lj   <= s_axis_tdata[67];
                        r_zp   <= s_axis_tdata[68];
                        r_sp   <= s_axis_tdata[69];
                        r_ss   <= s_axis_tdata[70];
                        r_alt  <= s_axis_tdata[71];
                        r_fw   <= s_axis_tdata[79:72];
                        r_md   <= s_axis_tdata[88:80];
                        r_nil  <= (s_axis_tuser == itaf_pkg::FUNC_PTR) &&
                                  (s_axis_tdata[63:0] == 64'd0);
                        if (s_axis_tdata[89]) begin
                            r_cw <= '0;
                        end
                        r_state <= S_PREP;
                    end
                end
                S_PREP: begin
                    r_mag  <= n_mag;
                    r_neg  <= n_neg;
                    r_nd   <= '0;
                    r_state <= r_nil ? S_LAY1 : S_DIGITS;
                end
                S_DIGITS: begin
                    r_zero <= (r_mag == 64'd0);
                    if (w_rsp.done) begin
                        r_nd    <= w_rsp.nd;
                        r_state <= S_LAY1;
                    end
                end
                S_LAY1: begin
                    r_nd <= n_nd;
                    r_pre <= '0;
                    r_plen <= 3'd0;
                    if (r_nil) begin
                        r_pre  <= itaf_pkg::STR_NIL;
                        r_plen <= 3'd5;
                    end else begin
                        case (r_func)
                            itaf_pkg::FUNC_SDEC: begin
                                if (r_neg || r_sp || r_ss) begin
                                    r_plen <= 3'd1;
                                    r_pre[7:0] <= r_neg ? itaf_pkg::CH_MINUS :
                                                  r_sp ? itaf_pkg::CH_PLUS :
                                                  itaf_pkg::CH_SPACE;
                                end
                            end
                            itaf_pkg::FUNC_HEXL, itaf_pkg::FUNC_HEXU: begin
                                if (r_alt && !r_zero) begin
                                    r_plen <= 3'd2;
                                    r_pre[15:0] <= {(r_func == itaf_pkg::FUNC_HEXU) ?
                                                   itaf_pkg::CH_UX : itaf_pkg::CH_LX,
                                                   itaf_pkg::CH_ZERO};
                                end
                            end
                            itaf_pkg::FUNC_BIN: begin
                                if (r_alt && !r_zero) begin
                                    r_plen <= 3'd2;
                                    r_pre[15:0] <= {itaf_pkg::CH_LB, itaf_pkg::CH_ZERO};
                                end
                            end
                            itaf_pkg::FUNC_OCT: begin
                                if (r_alt && !r_zero &&
                                    !(n_has_prec && {1'b0, r_md[7:0]} > {2'b0, n_nd})) begin
                                    r_plen <= 3'd1;
                                    r_pre[7:0] <= itaf_pkg::CH_ZERO;
                                end
                            end
                            itaf_pkg::FUNC_PTR: begin
                                r_plen <= 3'd2;
                                r_pre[15:0] <= {itaf_pkg::CH_LX, itaf_pkg::CH_ZERO};
                            end
                            default: r_plen <= 3'd0;
                        endcase
                    end
                    r_state <= S_LAY2;
                end
                S_LAY2: begin
                    r_ppad <= (!r_nil && n_has_prec && {1'b0, r_md[7:0]} > {2'b0, r_nd}) ?
                              ({1'b0, r_md[7:0]} - {2'b0, r_nd}) : 9'd0;
                    r_content <= {7'b0, r_plen} + {3'b0, r_nd} +
                                 ((!r_nil && n_has_prec && {1'b0, r_md[7:0]} > {2'b0, r_nd}) ?
                                 ({2'b0, r_md[7:0]} - {3'b0, r_nd}) : 10'd0);
                    r_state <= S_LAY3;
                end
                S_LAY3: begin
                    r_fpad <= ({2'b0, n_fw} > r_content) ? ({2'b0, n_fw} - r_content) : '0;
                    r_state <= S_EMIT;
                    r_fill  <= '0;
                    r_buf   <= '0;
                    r_rem   <= '0;
                    r_dcnt  <= r_nd;
                    r_lpad  <= '0;
                    r_zpad  <= '0;
                    r_rpad  <= '0;
                end
                S_EMIT: begin
                    if (r_rem == '0 && r_fill == 4'd0 && r_lpad == '0 && r_zpad == '0 &&
                        r_rpad == '0 && r_fpad != 10'h3FF) begin
                        if (n_sum[31]) begin
                            r_state <= S_OVF;
                        end else if (r_fpad != 10'h3FF) begin
                            r_cw   <= n_sum[30:0];
                            r_rem  <= r_content + r_fpad;
                            r_lpad <= (!r_lj && !n_zfill) ? r_fpad : '0;
                            r_zpad <= n_zfill ? r_fpad : '0;
                            r_rpad <= r_lj ? r_fpad : '0;
                            r_fpad <= 10'h3FF;
                        end
                    end else if (n_gen) begin
                        r_buf[r_fill[2:0]*8 +: 8] <= n_ch;
                        r_fill <= r_fill + 4'd1;
                        r_rem  <= r_rem - 10'd1;
                        if (r_lpad != '0) begin
                            r_lpad <= r_lpad - 10'd1;
                        end else if (r_plen != 3'd0) begin
                            r_plen <= r_plen - 3'd1;
                            r_pre  <= r_pre >> 8;
                        end else if (r_zpad != '0) begin
                            r_zpad <= r_zpad - 10'd1;
                        end else if (r_ppad != '0) begin
                            r_ppad <= r_ppad - 9'd1;
                        end else if (r_dcnt != 7'd0) begin
                            r_dcnt <= r_dcnt - 7'd1;
                        end else begin
                            r_rpad <= r_rpad - 10'd1;
                        end
                    end else if (n_out_free) begin
                        r_out_valid <= 1'b1;
                        r_out_chars <= r_buf;
                        r_out_cnt   <= r_fill;
                        r_out_last  <= (r_rem == '0);
                        r_out_ovf   <= 1'b0;
                        r_buf       <= '0;
                        r_fill      <= '0;
                        if (r_rem == '0) begin
                            r_state <= S_IDLE;
                        end
                    end
                end
                S_OVF: begin
                    if (n_out_free) begin
                        r_out_valid <= 1'b1;
                        r_out_chars <= '0;
                        r_out_cnt   <= '0;
                        r_out_last  <= 1'b1;
                        r_out_ovf   <= 1'b1;
                        r_state     <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign s_axis_tready = (r_state == S_IDLE);
    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {4'b0, r_out_cnt, r_out_chars};
    assign m_axis_tuser  = r_out_ovf;
    assign m_axis_tlast  = r_out_last;

endmodule

// File: rtl/core/itaf_digits.sv
// Digit generator: binary to BCD by shift and add-three for decimal, then digit extraction.
// Depends on itaf_pkg.
module itaf_digits (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  itaf_pkg::t_dig_req  i_req,
    input  logic [63:0]         i_mag,
    output itaf_pkg::t_dig_rsp  o_rsp
);

    typedef enum logic [1:0] {D_IDLE, D_DABBLE, D_EXTRACT} t_dstate;

    t_dstate                         r_state;
    logic [63:0]                     r_bin;
    logic [itaf_pkg::BCD_W-1:0]      r_sh;
    logic [6:0]                      r_cnt;
    logic [2:0]                      r_k;
    logic [itaf_pkg::BCD_W-1:0]      n_adj;
    logic [itaf_pkg::BCD_W-1:0]      n_next;
    logic [3:0]                      n_mask;
    logic                            n_stop;

    always_comb begin
        for (int i = 0; i < itaf_pkg::BCD_W / 4; i++) begin
            n_adj[i*4 +: 4] = (r_sh[i*4 +: 4] >= 4'd5) ? r_sh[i*4 +: 4] + 4'd3
                                                       : r_sh[i*4 +: 4];
        end
    end

    always_comb begin
        case (r_k)
            3'd1: begin
                n_next = r_sh >> 1;
                n_mask = 4'h1;
            end
            3'd3: begin
                n_next = r_sh >> 3;
                n_mask = 4'h7;
            end
            default: begin
                n_next = r_sh >> 4;
                n_mask = 4'hF;
            end
        endcase
    end

    assign n_stop = (n_next == '0) || (r_cnt[5:0] == 6'(itaf_pkg::MAX_DIGITS - 1));

    always_comb begin
        o_rsp.wr_en    = (r_state == D_EXTRACT);
        o_rsp.wr_addr  = r_cnt[5:0];
        o_rsp.wr_digit = r_sh[3:0] & n_mask;
        o_rsp.done     = (r_state == D_EXTRACT) && n_stop;
        o_rsp.nd       = r_cnt + 7'd1;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= D_IDLE;
            r_cnt   <= '0;
        end else begin
            case (r_state)
                D_IDLE: begin
                    if (i_req.start) begin
                        r_cnt <= '0;
                        if (i_req.is_dec) begin
                            r_bin   <= i_mag;
                            r_sh    <= '0;
                            r_k     <= 3'd4;
                            r_state <= D_DABBLE;
                        end else begin
                            r_sh    <= {16'b0, i_mag};
                            r_k     <= i_req.shift;
                            r_state <= D_EXTRACT;
                        end
                    end
                end
                D_DABBLE: begin
                    r_sh  <= {n_adj[itaf_pkg::BCD_W-2:0], r_bin[63]};
                    r_bin <= {r_bin[62:0], 1'b0};
                    if (r_cnt == 7'd63) begin
                        r_cnt   <= '0;
                        r_state <= D_EXTRACT;
                    end else begin
                        r_cnt <= r_cnt + 7'd1;
                    end
                end
                D_EXTRACT: begin
                    r_sh <= n_next;
                    if (n_stop) begin
                        r_state <= D_IDLE;
                    end else begin
                        r_cnt <= r_cnt + 7'd1;
                    end
                end
                default: r_state <= D_IDLE;
            endcase
        end
    end

endmodule
